### rtl/fedt_pkg.sv
// ----------------------------------------------------------------------------
// fedt_pkg: shared types and constants of the flit erasure decodability tracker
// Holds the command word passed from the front end to the back end, the
// configuration bundle, and the codes used across the block.
// ----------------------------------------------------------------------------
package fedt_pkg;

  // Map and geometry sizing
  localparam int MaxFlits = 32;
  localparam int ScanW    = MaxFlits + 1;          // map positions plus one spill slot
  localparam int ScanIdxW = $clog2(ScanW + 1);     // holds a clipped end up to ScanW
  localparam int ScanLv   = $clog2(ScanW);         // levels of the segmented scan

  // Command queue sizing
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef logic [ScanIdxW-1:0] scan_idx_t;
  typedef logic [QPtrW-1:0]    q_ptr_t;
  typedef logic [QCntW-1:0]    q_cnt_t;

  // Verdict codes
  localparam logic [1:0] VerdictNone = 2'd0;
  localparam logic [1:0] VerdictDec  = 2'd1;
  localparam logic [1:0] VerdictFail = 2'd2;

  // Code modes
  localparam logic [1:0] ModeUncoded = 2'd0;

  // Reply modes
  localparam logic [1:0] ReplyAck  = 2'd1;
  localparam logic [1:0] ReplyNack = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgCodeMode  = 2'd0;
  localparam logic [1:0] CfgReplyMode = 2'd1;
  localparam logic [1:0] CfgEndCount  = 2'd2;
  localparam logic [1:0] CfgBlockSize = 2'd3;

  // Front end classification of an incoming word
  typedef enum logic [1:0] {
    OpFlit,
    OpHead,
    OpEnd
  } op_e;

  // What the back end has to do once the state update is done
  typedef enum logic [1:0] {
    KindNone,
    KindCheck,
    KindFail
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic       is_tail;
    logic [4:0] flit_seq;
    logic [5:0] total_flits;
    logic [5:0] base_flits;
    logic [4:0] code_flits;
  } cmd_t;

  typedef struct packed {
    logic [1:0] code_mode;
    logic [1:0] reply_mode;
    logic       end_by_count;
    logic [4:0] block_size;
  } cfg_t;

endpackage

### rtl/fedt_if.sv
// ----------------------------------------------------------------------------
// fedt_if: input and output channels of the decodability tracker
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface fedt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic       is_head;
  logic       is_tail;
  logic [4:0] flit_seq;
  logic [5:0] total_flits;
  logic [5:0] base_flits;
  logic [4:0] code_flits;

  modport source (
    output valid, action, is_head, is_tail, flit_seq, total_flits, base_flits,
           code_flits,
    input  ready
  );
  modport sink (
    input  valid, action, is_head, is_tail, flit_seq, total_flits, base_flits,
           code_flits,
    output ready
  );
endinterface

interface fedt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       send_ack;
  logic       send_nack;
  logic       forward_head;
  logic [5:0] received_count;

  modport source (
    output valid, verdict, send_ack, send_nack, forward_head, received_count,
    input  ready
  );
  modport sink (
    input  valid, verdict, send_ack, send_nack, forward_head, received_count,
    output ready
  );
endinterface

### rtl/fedt_front.sv
// ----------------------------------------------------------------------------
// fedt_front: input stage of the decodability tracker
// Registers each incoming word, classifies it as flit, head or end event,
// and hands it to the command queue.
// ----------------------------------------------------------------------------
module fedt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  fedt_in_if.sink         in_ch,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output fedt_pkg::cmd_t  push_cmd_o
);

  logic           vld_q, vld_d;
  fedt_pkg::cmd_t cmd_q, cmd_d;
  logic           take;

  // Accept when the stage is empty or drains this cycle
  assign in_ch.ready = !vld_q || push_ready_i;
  assign take        = in_ch.valid && in_ch.ready;

  // Classify and load the stage
  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (take) begin
      vld_d = 1'b1;
      if (in_ch.action) begin
        cmd_d.op = fedt_pkg::OpEnd;
      end else if (in_ch.is_head) begin
        cmd_d.op = fedt_pkg::OpHead;
      end else begin
        cmd_d.op = fedt_pkg::OpFlit;
      end
      cmd_d.is_tail     = in_ch.is_tail;
      cmd_d.flit_seq    = in_ch.flit_seq;
      cmd_d.total_flits = in_ch.total_flits;
      cmd_d.base_flits  = in_ch.base_flits;
      cmd_d.code_flits  = in_ch.code_flits;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign push_valid_o = vld_q;
  assign push_cmd_o   = cmd_q;

endmodule

### rtl/fedt_fifo.sv
// ----------------------------------------------------------------------------
// fedt_fifo: command queue between front and back end
// A short register queue so that the front can keep taking words while the
// back end works through a geometry pass or waits on the output.
// ----------------------------------------------------------------------------
module fedt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fedt_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fedt_pkg::cmd_t  pop_cmd_o
);

  fedt_pkg::cmd_t   mem_q [fedt_pkg::QDepth];
  fedt_pkg::q_ptr_t wptr_q, wptr_d, rptr_q, rptr_d;
  fedt_pkg::q_cnt_t cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q < fedt_pkg::q_cnt_t'(fedt_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rptr_q];

  // Advance pointers with explicit wrap
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == fedt_pkg::q_ptr_t'(fedt_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == fedt_pkg::q_ptr_t'(fedt_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/fedt_back.sv
// ----------------------------------------------------------------------------
// fedt_back: packet state and decodability check
// Pops a command, updates the received map and latched counts, builds the
// XOR block geometry when it is stale (remainder divider, then a walk over
// the blocks), and checks the packet with a segmented scan over the map.
// ----------------------------------------------------------------------------
module fedt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fedt_pkg::cfg_t  cfg_i,
  input  logic            cfg_wr_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  fedt_pkg::cmd_t  cmd_i,
  fedt_out_if.source      out_ch
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StBlk  = 2'd2;
  localparam logic [1:0] StChk  = 2'd3;

  logic [1:0] state_q, state_d;

  // Packet state
  logic [fedt_pkg::MaxFlits-1:0] map_q, map_d;
  logic [5:0]                    cnt_q, cnt_d;
  logic                          en_q, en_d;
  logic [5:0]                    tot_q, tot_d;
  logic [5:0]                    base_q, base_d;
  logic [4:0]                    code_q, code_d;
  fedt_pkg::kind_e               kind_q, kind_d;
  logic                          tail_q, tail_d;

  // Block geometry
  logic                           geo_ok_q, geo_ok_d;
  logic [5:0]                     rem_q, rem_d;
  logic [2:0]                     bit_q, bit_d;
  logic [4:0]                     blk_q, blk_d;
  logic [9:0]                     start_q, start_d;
  logic [fedt_pkg::ScanW-1:0]     smask_q, smask_d;
  fedt_pkg::scan_idx_t            end_q, end_d;
  logic                           sfail_q, sfail_d;

  // Output register
  logic       out_vld_q, out_vld_d;
  logic [1:0] verdict_q, verdict_d;
  logic       ack_q, ack_d, nack_q, nack_d, fwd_q, fwd_d;
  logic [5:0] cnt_out_q, cnt_out_d;

  // Working signals
  logic [5:0]                 span;
  logic [6:0]                 pay;
  logic [6:0]                 trial;
  logic [5:0]                 nlast, blk_len;
  logic                       blk_last;
  logic [10:0]                blk_end;
  logic [9:0]                 blk_lo;
  logic [fedt_pkg::ScanW-1:0] cov, miss, sf, sb, nf, nb;
  logic                       scan_fail, blocks_ok, dec, out_free;
  logic [fedt_pkg::MaxFlits-1:0] map_base;
  logic [5:0]                 cnt_base;
  logic                       en_now, is_head;

  assign span        = {1'b0, cfg_i.block_size} + 6'd1;
  assign pay         = {1'b0, tot_q} - (cfg_i.end_by_count ? 7'd1 : 7'd2);
  assign trial       = {rem_q, pay[bit_q]};
  assign nlast       = pay[6] ? 6'd0 : ((rem_q == 6'd0) ? span : rem_q);
  assign blk_last    = (blk_q == (code_q - 5'd1));
  assign blk_len     = blk_last ? nlast : span;
  assign blk_end     = {1'b0, start_q} + {5'd0, blk_len};
  assign blk_lo      = (start_q > 10'(fedt_pkg::MaxFlits)) ? start_q : 10'(fedt_pkg::MaxFlits);
  assign out_free    = !out_vld_q || out_ch.ready;
  assign cmd_ready_o = (state_q == StIdle);

  // Mark covered positions and the misses among them
  always_comb begin
    for (int p = 0; p < fedt_pkg::ScanW; p++) begin
      cov[p] = (p >= 1) && (fedt_pkg::scan_idx_t'(p) < end_q);
    end
    miss = cov & ~{1'b0, map_q};
  end

  // Segmented OR scan: sf[p] is set when a miss lies in p's block at or before p
  always_comb begin
    sf = miss;
    sb = smask_q;
    for (int lv = 0; lv < fedt_pkg::ScanLv; lv++) begin
      for (int p = 0; p < fedt_pkg::ScanW; p++) begin
        if (p >= (1 << lv)) begin
          nf[p] = sf[p] | (~sb[p] & sf[p - (1 << lv)]);
          nb[p] = sb[p] | sb[p - (1 << lv)];
        end else begin
          nf[p] = sf[p];
          nb[p] = sb[p];
        end
      end
      sf = nf;
      sb = nb;
    end
  end

  // A second miss in one block fails it
  assign scan_fail = |(miss & {sf[fedt_pkg::ScanW-2:0], 1'b0} & ~smask_q);
  assign blocks_ok = !sfail_q && !scan_fail;
  assign dec       = (cfg_i.code_mode == fedt_pkg::ModeUncoded) ||
                     ((cnt_q >= base_q) && (!cfg_i.code_mode[1] || blocks_ok));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    map_d     = map_q;
    cnt_d     = cnt_q;
    en_d      = en_q;
    tot_d     = tot_q;
    base_d    = base_q;
    code_d    = code_q;
    kind_d    = kind_q;
    tail_d    = tail_q;
    geo_ok_d  = geo_ok_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    blk_d     = blk_q;
    start_d   = start_q;
    smask_d   = smask_q;
    end_d     = end_q;
    sfail_d   = sfail_q;
    out_vld_d = out_vld_q;
    verdict_d = verdict_q;
    ack_d     = ack_q;
    nack_d    = nack_q;
    fwd_d     = fwd_q;
    cnt_out_d = cnt_out_q;
    is_head   = 1'b0;
    en_now    = en_q;
    map_base  = map_q;
    cnt_base  = cnt_q;

    // Drop the output word once taken
    if (out_vld_q && out_ch.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          tail_d = cmd_i.is_tail;
          if (cmd_i.op == fedt_pkg::OpEnd) begin
            if (cfg_i.end_by_count && en_q) begin
              kind_d = fedt_pkg::KindFail;
              en_d   = 1'b0;
            end else begin
              kind_d = fedt_pkg::KindNone;
            end
            state_d = StChk;
          end else begin
            is_head = (cmd_i.op == fedt_pkg::OpHead);
            en_now  = is_head || en_q;
            if (is_head) begin
              tot_d    = cmd_i.total_flits;
              base_d   = cmd_i.base_flits;
              code_d   = cmd_i.code_flits;
              map_base = '0;
              cnt_base = 6'd0;
              en_d     = 1'b1;
              geo_ok_d = 1'b0;
            end
            map_d = map_base;
            cnt_d = cnt_base;
            if (en_now && (int'(cmd_i.flit_seq) < fedt_pkg::MaxFlits)) begin
              map_d[cmd_i.flit_seq] = 1'b1;
              if (!map_base[cmd_i.flit_seq]) begin
                cnt_d = cnt_base + 6'd1;
              end
            end
            kind_d = en_now ? fedt_pkg::KindCheck : fedt_pkg::KindNone;
            // Rebuild the block geometry when the check needs it
            if (en_now && cfg_i.code_mode[1] && (is_head || !geo_ok_q)) begin
              rem_d   = 6'd0;
              bit_d   = 3'd5;
              blk_d   = 5'd0;
              start_d = 10'd1;
              smask_d = '0;
              end_d   = '0;
              sfail_d = 1'b0;
              state_d = StDiv;
            end else begin
              state_d = StChk;
            end
          end
        end
      end

      StDiv: begin
        // One remainder bit per cycle: payload mod span
        if (trial >= {1'b0, span}) begin
          rem_d = 6'(trial - {1'b0, span});
        end else begin
          rem_d = trial[5:0];
        end
        bit_d = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          if (code_q == 5'd0) begin
            geo_ok_d = 1'b1;
            state_d  = StChk;
          end else begin
            state_d = StBlk;
          end
        end
      end

      StBlk: begin
        // Walk one block per cycle
        if (start_q <= 10'(fedt_pkg::MaxFlits)) begin
          smask_d[start_q[fedt_pkg::ScanIdxW-1:0]] = 1'b1;
        end
        if (blk_end >= ({1'b0, blk_lo} + 11'd2)) begin
          sfail_d = 1'b1;
        end
        if (blk_last) begin
          end_d    = (blk_end > 11'(fedt_pkg::ScanW)) ?
                     fedt_pkg::scan_idx_t'(fedt_pkg::ScanW) :
                     blk_end[fedt_pkg::ScanIdxW-1:0];
          geo_ok_d = 1'b1;
          state_d  = StChk;
        end else begin
          start_d = start_q + {4'd0, span};
          blk_d   = blk_q + 5'd1;
        end
      end

      StChk: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          verdict_d = fedt_pkg::VerdictNone;
          ack_d     = 1'b0;
          nack_d    = 1'b0;
          fwd_d     = 1'b0;
          cnt_out_d = cnt_q;
          case (kind_q)
            fedt_pkg::KindFail: begin
              verdict_d = fedt_pkg::VerdictFail;
              nack_d    = (cfg_i.reply_mode == fedt_pkg::ReplyNack);
            end
            fedt_pkg::KindCheck: begin
              if (dec) begin
                en_d      = 1'b0;
                verdict_d = fedt_pkg::VerdictDec;
                ack_d     = (cfg_i.reply_mode == fedt_pkg::ReplyAck);
                fwd_d     = 1'b1;
              end else if (tail_q) begin
                en_d      = 1'b0;
                verdict_d = fedt_pkg::VerdictFail;
                nack_d    = (cfg_i.reply_mode == fedt_pkg::ReplyNack);
              end
            end
            default: begin
            end
          endcase
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // A register write may change the block layout
    if (cfg_wr_i) begin
      geo_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      map_q     <= '0;
      cnt_q     <= 6'd0;
      en_q      <= 1'b0;
      tot_q     <= 6'd0;
      base_q    <= 6'd0;
      code_q    <= 5'd0;
      geo_ok_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      map_q     <= map_d;
      cnt_q     <= cnt_d;
      en_q      <= en_d;
      tot_q     <= tot_d;
      base_q    <= base_d;
      code_q    <= code_d;
      geo_ok_q  <= geo_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    tail_q    <= tail_d;
    rem_q     <= rem_d;
    bit_q     <= bit_d;
    blk_q     <= blk_d;
    start_q   <= start_d;
    smask_q   <= smask_d;
    end_q     <= end_d;
    sfail_q   <= sfail_d;
    verdict_q <= verdict_d;
    ack_q     <= ack_d;
    nack_q    <= nack_d;
    fwd_q     <= fwd_d;
    cnt_out_q <= cnt_out_d;
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.verdict        = verdict_q;
  assign out_ch.send_ack       = ack_q;
  assign out_ch.send_nack      = nack_q;
  assign out_ch.forward_head   = fwd_q;
  assign out_ch.received_count = cnt_out_q;

endmodule

### rtl/flit_erasure_decodability_tracker.sv
// Path: an accepted word is registered in the front stage, held in the command
// queue, popped by the back end, checked there and loaded into the output register.
// The back end pops only from idle. In block XOR mode a head, or the first flit
// after a register write, adds the remainder divider, then the walk over the blocks.
// Reset: control state, packet state and map clear; registers take reset values.
// ----------------------------------------------------------------------------
// flit_erasure_decodability_tracker: erasure-coded packet receiver check
// Holds the configuration registers and joins the front stage, the command
// queue and the back end that tracks decodability of each packet.
// ----------------------------------------------------------------------------
module flit_erasure_decodability_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  fedt_in_if.sink    in_ch,
  fedt_out_if.source out_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i
);

  fedt_pkg::cfg_t cfg_q, cfg_d;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  fedt_pkg::cmd_t push_cmd, pop_cmd;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fedt_pkg::CfgCodeMode:  cfg_d.code_mode    = cfg_data_i[1:0];
        fedt_pkg::CfgReplyMode: cfg_d.reply_mode   = cfg_data_i[1:0];
        fedt_pkg::CfgEndCount:  cfg_d.end_by_count = cfg_data_i[0];
        fedt_pkg::CfgBlockSize: cfg_d.block_size   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_mode    <= 2'd1;
      cfg_q.reply_mode   <= 2'd1;
      cfg_q.end_by_count <= 1'b0;
      cfg_q.block_size   <= 5'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fedt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  fedt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  fedt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_we_i),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_ch      (out_ch)
  );

endmodule

### rtl/fedt_checker.sv
// ----------------------------------------------------------------------------
// fedt_checker: port-level checks of the decodability tracker
// Watches the output channel for consistent reply and verdict words.
// ----------------------------------------------------------------------------
module fedt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] verdict_i,
  input logic       send_ack_i,
  input logic       send_nack_i,
  input logic       forward_head_i,
  input logic [5:0] received_count_i
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i) &&
    $stable(send_ack_i) && $stable(send_nack_i) && $stable(forward_head_i) &&
    $stable(received_count_i))
    else $error("stalled output word changed");

  // ACK only with a decode and a head forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_ack_i |-> verdict_i == fedt_pkg::VerdictDec && forward_head_i)
    else $error("ACK without decode");

  // NACK only with a failure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_nack_i |-> verdict_i == fedt_pkg::VerdictFail && !forward_head_i)
    else $error("NACK without failure");

  // No reply and no forward when nothing is decided
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i == fedt_pkg::VerdictNone |->
    !send_ack_i && !send_nack_i && !forward_head_i)
    else $error("reply on undecided word");

  // Count never exceeds the map size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> int'(received_count_i) <= fedt_pkg::MaxFlits)
    else $error("received count out of range");

endmodule

bind flit_erasure_decodability_tracker fedt_checker u_fedt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .verdict_i        (out_ch.verdict),
  .send_ack_i       (out_ch.send_ack),
  .send_nack_i      (out_ch.send_nack),
  .forward_head_i   (out_ch.forward_head),
  .received_count_i (out_ch.received_count)
);
